// ===== sv/paq_pkg.sv =====
// ----------------------------------------------------------------------------
// paq_pkg: shared types and constants of the priority admission command queue
// Holds the queue and worker pool sizes, the command, priority and status
// codes, the register indexes and the item types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package paq_pkg;

	// Sizes of the queue and of the worker pool.
	localparam int QUEUE_DEPTH  = 16;
	localparam int WORKER_COUNT = 8;
	localparam int TAG_BITS     = 16;

	// Derived widths.
	localparam int HEAD_BITS   = $clog2(QUEUE_DEPTH);
	localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_BITS    = COUNT_BITS + 1;
	localparam int WORKER_BITS = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;

	// Fixed field widths of the channels.
	localparam int CMD_BITS    = 2;
	localparam int PRIO_BITS   = 2;
	localparam int FWORK_BITS  = 3;
	localparam int STATUS_BITS = 2;
	localparam int FILL_BITS   = 5;
	localparam int DROP_BITS   = 32;
	localparam int LIMIT_BITS  = 5;
	localparam int CMP_BITS    = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
	localparam int FWCMP_BITS  = (FWORK_BITS > 7) ? FWORK_BITS + 1 : 8;

	// Configuration port.
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NORMAL_LIMIT    = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DROPPABLE_LIMIT = 1'd1;
	localparam logic [LIMIT_BITS-1:0]   NORMAL_LIMIT_RESET    = 5'd12;
	localparam logic [LIMIT_BITS-1:0]   DROPPABLE_LIMIT_RESET = 5'd4;

	// Command codes.
	localparam logic [CMD_BITS-1:0] CMD_SUBMIT     = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_FREE       = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR_DROP = 2'd2;

	// Priority classes.
	localparam logic [PRIO_BITS-1:0] PRIO_URGENT = 2'd0;
	localparam logic [PRIO_BITS-1:0] PRIO_NORMAL = 2'd1;

	// Status codes.
	localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_DROP_LIMIT = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_DROP_FULL  = 2'd2;

	typedef struct packed {
		logic [CMD_BITS-1:0]   command;
		logic [PRIO_BITS-1:0]  priority_req;
		logic [TAG_BITS-1:0]   command_tag;
		logic [FWORK_BITS-1:0] freed_worker;
	} cmd_item_t;

	typedef struct packed {
		logic                   dispatch_valid;
		logic [TAG_BITS-1:0]    dispatch_tag;
		logic [FWORK_BITS-1:0]  dispatch_worker;
		logic [STATUS_BITS-1:0] status;
		logic [FILL_BITS-1:0]   fill_level;
		logic [DROP_BITS-1:0]   drop_total;
	} res_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic admit;
		logic finish;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic res_busy;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/paq_ctrl.sv =====
// ----------------------------------------------------------------------------
// paq_ctrl: sequencing controller
// Steps each item through capture, admission and dispatch, and holds the
// input stall while an item is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_stall,
	input  paq_pkg::dp_status_t  dp_status,
	output paq_pkg::ctl_cmd_t    ctl_cmd
);
	import paq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADMIT,
		ST_DISPATCH
	} state_t;

	state_t state_q;
	logic   stall_q;

	// Command decode from the current state.
	always_comb begin
		ctl_cmd.capture = (state_q == ST_IDLE) && cmd_valid;
		ctl_cmd.admit   = (state_q == ST_ADMIT);
		ctl_cmd.finish  = (state_q == ST_DISPATCH) && !dp_status.res_busy;
	end

	assign cmd_stall = stall_q;

	// State register and registered stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_ADMIT;
						stall_q <= 1'b1;
					end
				end
				ST_ADMIT: begin
					state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					if (!dp_status.res_busy) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/paq_datapath.sv =====
// ----------------------------------------------------------------------------
// paq_datapath: queue store, pointers, worker mask and result register
// Performs admission of a captured item, then the dispatch of the queue head
// to the lowest free worker, and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_datapath (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  paq_pkg::ctl_cmd_t                    ctl_cmd,
	output paq_pkg::dp_status_t                  dp_status,
	input  paq_pkg::cmd_item_t                   cmd_item,
	input  wire                                  cfg_write,
	input  wire [paq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire [paq_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output logic                                 res_valid,
	input  wire                                  res_stall,
	output paq_pkg::res_item_t                   res_item
);
	import paq_pkg::*;

	// Captured item.
	cmd_item_t item_q;

	// Queue and pool state.
	logic [TAG_BITS-1:0]     store_q [QUEUE_DEPTH];
	logic [HEAD_BITS-1:0]    head_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [WORKER_COUNT-1:0] free_q;
	logic [DROP_BITS-1:0]    drop_q;
	logic [LIMIT_BITS-1:0]   normal_limit_q;
	logic [LIMIT_BITS-1:0]   droppable_limit_q;
	logic [STATUS_BITS-1:0]  status_q;
	logic                    try_q;

	// Result register.
	logic      res_valid_q;
	res_item_t res_q;

	// Admission signals.
	logic [SUM_BITS-1:0]    tail_sum;
	logic [HEAD_BITS-1:0]   tail_idx;
	logic [HEAD_BITS-1:0]   head_dec;
	logic [LIMIT_BITS-1:0]  limit_sel;
	logic                   queue_full;
	logic                   below_limit;
	logic                   wr_en;
	logic [HEAD_BITS-1:0]   wr_idx;
	logic [DROP_BITS-1:0]   drop_inc;
	logic                   fw_in_range;
	logic [WORKER_COUNT-1:0] free_set;

	// Dispatch signals.
	logic [HEAD_BITS-1:0]   head_inc;
	logic                   any_free;
	logic [WORKER_BITS-1:0] sel_worker;
	logic [FWORK_BITS-1:0]  sel_field;
	logic                   disp;
	logic [COUNT_BITS-1:0]  count_after;

	assign dp_status.res_busy = res_valid_q && res_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Queue index arithmetic with wraparound.
	always_comb begin
		tail_sum = SUM_BITS'(head_q) + SUM_BITS'(count_q);
		if (tail_sum >= SUM_BITS'(QUEUE_DEPTH)) begin
			tail_idx = HEAD_BITS'(tail_sum - SUM_BITS'(QUEUE_DEPTH));
		end else begin
			tail_idx = HEAD_BITS'(tail_sum);
		end
		if (head_q == '0) begin
			head_dec = HEAD_BITS'(QUEUE_DEPTH - 1);
		end else begin
			head_dec = head_q - 1'b1;
		end
		if (head_q == HEAD_BITS'(QUEUE_DEPTH - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + 1'b1;
		end
	end

	// Admission checks. Priority three shares the droppable limit.
	always_comb begin
		limit_sel   = (item_q.priority_req == PRIO_NORMAL) ? normal_limit_q : droppable_limit_q;
		queue_full  = (count_q == COUNT_BITS'(QUEUE_DEPTH));
		below_limit = (CMP_BITS'(count_q) < CMP_BITS'(limit_sel)) && !queue_full;
		drop_inc    = (drop_q == '1) ? drop_q : drop_q + 1'b1;
		fw_in_range = (FWCMP_BITS'(item_q.freed_worker) < FWCMP_BITS'(WORKER_COUNT));
		wr_en       = 1'b0;
		wr_idx      = tail_idx;
		if (ctl_cmd.admit && item_q.command == CMD_SUBMIT) begin
			if (item_q.priority_req == PRIO_URGENT) begin
				wr_en  = !queue_full;
				wr_idx = head_dec;
			end else begin
				wr_en  = below_limit;
				wr_idx = tail_idx;
			end
		end
	end

	// One-hot of the freed worker.
	always_comb begin
		free_set = '0;
		for (int w = 0; w < WORKER_COUNT; w++) begin
			if (fw_in_range && FWCMP_BITS'(item_q.freed_worker) == FWCMP_BITS'(w)) begin
				free_set[w] = 1'b1;
			end
		end
	end

	// Lowest free worker.
	always_comb begin
		sel_worker = '0;
		for (int w = WORKER_COUNT - 1; w >= 0; w--) begin
			if (free_q[w]) begin
				sel_worker = WORKER_BITS'(w);
			end
		end
		any_free    = |free_q;
		sel_field   = FWORK_BITS'(sel_worker);
		disp        = try_q && (count_q != '0) && any_free;
		count_after = disp ? count_q - 1'b1 : count_q;
	end

	// Queue store, written at admission only.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_idx] <= item_q.command_tag;
		end
	end

	// Captured item.
	always_ff @(posedge clk) begin
		if (ctl_cmd.capture) begin
			item_q <= cmd_item;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ctl_cmd.finish) begin
			res_q.dispatch_valid  <= disp;
			res_q.dispatch_tag    <= disp ? store_q[head_q] : '0;
			res_q.dispatch_worker <= disp ? sel_field : '0;
			res_q.status          <= status_q;
			res_q.fill_level      <= FILL_BITS'(count_after);
			res_q.drop_total      <= drop_q;
		end
	end

	// Control state: pointers, worker mask, counters, limits and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q            <= '0;
			count_q           <= '0;
			free_q            <= '1;
			drop_q            <= '0;
			normal_limit_q    <= NORMAL_LIMIT_RESET;
			droppable_limit_q <= DROPPABLE_LIMIT_RESET;
			status_q          <= STATUS_OK;
			try_q             <= 1'b0;
			res_valid_q       <= 1'b0;
		end else begin
			// Register writes.
			if (cfg_write) begin
				case (cfg_index)
					CFG_NORMAL_LIMIT:    normal_limit_q    <= LIMIT_BITS'(cfg_data);
					CFG_DROPPABLE_LIMIT: droppable_limit_q <= LIMIT_BITS'(cfg_data);
					default: begin
					end
				endcase
			end

			// Admission step.
			if (ctl_cmd.admit) begin
				status_q <= STATUS_OK;
				try_q    <= 1'b0;
				case (item_q.command)
					CMD_SUBMIT: begin
						if (item_q.priority_req == PRIO_URGENT) begin
							if (queue_full) begin
								drop_q   <= drop_inc;
								status_q <= STATUS_DROP_FULL;
							end else begin
								head_q  <= head_dec;
								count_q <= count_q + 1'b1;
								try_q   <= 1'b1;
							end
						end else begin
							if (below_limit) begin
								count_q <= count_q + 1'b1;
								try_q   <= 1'b1;
							end else begin
								drop_q   <= drop_inc;
								status_q <= STATUS_DROP_LIMIT;
							end
						end
					end
					CMD_FREE: begin
						free_q <= free_q | free_set;
						try_q  <= 1'b1;
					end
					CMD_CLEAR_DROP: begin
						drop_q <= '0;
					end
					default: begin
					end
				endcase
			end

			// Dispatch step and result load.
			if (ctl_cmd.finish) begin
				if (disp) begin
					head_q  <= head_inc;
					count_q <= count_after;
					free_q[sel_worker] <= 1'b0;
				end
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/priority_admission_command_queue_top.sv =====
// ----------------------------------------------------------------------------
// priority_admission_command_queue_top: command queue with priority admission
// Each item passes through the controller states in turn: it is accepted
// and captured, the admission update of the queue is made, and the queue
// head is dispatched to the lowest free worker, which loads the result
// register. The controller takes no new item until the current one has
// passed the dispatch step; the next item is accepted while a result still
// waits, and the dispatch step waits only while the result register is held
// by a stall. Every item gives exactly one result. The queue store needs no
// clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_admission_command_queue_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cmd_valid,
	output logic                             cmd_stall,
	input  paq_pkg::cmd_item_t               cmd_item,
	output logic                             res_valid,
	input  wire                              res_stall,
	output paq_pkg::res_item_t               res_item,
	input  wire                              cfg_write,
	input  wire [paq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [paq_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import paq_pkg::*;

	ctl_cmd_t   ctl_cmd;
	dp_status_t dp_status;

	// Sequencing controller.
	paq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.dp_status (dp_status),
		.ctl_cmd   (ctl_cmd)
	);

	// Queue datapath.
	paq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_cmd   (ctl_cmd),
		.dp_status (dp_status),
		.cmd_item  (cmd_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

// ===== sv/paq_checker.sv =====
// ----------------------------------------------------------------------------
// paq_checker: port-level checks of the command queue
// Watches the input channel for the stall that follows an accepted item, and
// the result channel for a held stalled item and for consistent dispatch,
// status and fill level fields.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 cmd_valid,
	input wire                 cmd_stall,
	input wire                 res_valid,
	input wire                 res_stall,
	input paq_pkg::res_item_t  res_item
);
	import paq_pkg::*;

	// An accepted item occupies the block, so the input stalls next cycle.
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("input not stalled after an accepted item");

	// A stalled result item stays and holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result item changed while stalled");

	// The fill level never passes the queue depth.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.fill_level <= FILL_BITS'(QUEUE_DEPTH))
		else $error("fill level beyond queue depth");

	// Without a dispatch the tag and worker fields are zero.
	a_no_dispatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.dispatch_valid |->
			res_item.dispatch_tag == '0 && res_item.dispatch_worker == '0)
		else $error("dispatch fields set without a dispatch");

	// A full-queue drop leaves the queue full, and a dispatch never drops.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == STATUS_DROP_FULL |->
			res_item.fill_level == FILL_BITS'(QUEUE_DEPTH) && !res_item.dispatch_valid)
		else $error("queue full drop with inconsistent fill level");

endmodule

bind priority_admission_command_queue_top paq_checker u_paq_checker (.*);

`default_nettype wire
